// ===== design/block_cache_lru_directory_macros.svh =====
// ----------------------------------------------------------------------------
// Block cache LRU directory assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CACHE_LRU_DIRECTORY_MACROS_SVH
`define BLOCK_CACHE_LRU_DIRECTORY_MACROS_SVH

// assertion sampled on the rising clock, off while reset is low
`define BCLD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion that also holds during reset
`define BCLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bcld_pkg.sv =====
// ----------------------------------------------------------------------------
// Block cache LRU directory package
// Opcodes, result status codes and controller states.
// ----------------------------------------------------------------------------
package bcld_pkg;

    localparam logic [2:0] OP_GET       = 3'd0;
    localparam logic [2:0] OP_PUT       = 3'd1;
    localparam logic [2:0] OP_MARK      = 3'd2;
    localparam logic [2:0] OP_SYNC_DEV  = 3'd3;
    localparam logic [2:0] OP_SYNC_ALL  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MISS      = 3'd1;
    localparam logic [2:0] ST_ALL_PIN   = 3'd2;
    localparam logic [2:0] ST_WB_FAIL   = 3'd3;
    localparam logic [2:0] ST_RD_FAIL   = 3'd4;
    localparam logic [2:0] ST_IGNORED   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_GET_SCAN,
        S_GET_RES,
        S_SYNC_PICK,
        S_SYNC_READ,
        S_SYNC_EMIT
    } ctl_state_t;

endpackage

// ===== design/bcld_key_store.sv =====
// ----------------------------------------------------------------------------
// Block key store
// Synchronous block number memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module bcld_key_store #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/block_cache_lru_directory.sv =====
// ----------------------------------------------------------------------------
// Block cache LRU directory
// Tag directory of a block buffer cache: lookup, pinning, LRU replacement,
// writeback and sync of dirty slots.
//
//   channel  | dir | handshake          | payload
//   s_       | in  | s_valid / s_ready  | opcode, dev_id, block_num, slot, ok bits
//   m_       | out | m_valid / m_ready  | status, slot, writeback, read, last
//
// Put, mark dirty and ignored requests pass through the single-step state. Get
// scans the block key memory one slot a cycle, ending early on a hit, then emits.
// Sync picks, reads and emits each dirty slot in turn, or emits a single result
// when there is nothing to write back.
// One request is in flight at a time; output stalls hold the controller. Reset is
// synchronous, active low, clears valid, dirty, pin and device state of every slot
// and sets each LRU rank to its slot index; the block keys are not reset.
module block_cache_lru_directory
    import bcld_pkg::*;
#(
    parameter int NUM_SLOTS  = 32,
    parameter int DEVICES    = 16,
    parameter int BLOCK_BITS = 32,
    parameter int PIN_MAX    = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [3:0]  s_dev_id,
    input  logic [31:0] s_block_num,
    input  logic [4:0]  s_slot,
    input  logic        s_read_ok,
    input  logic        s_write_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [4:0]  m_slot_out,
    output logic        m_wb_valid,
    output logic [3:0]  m_wb_dev,
    output logic [31:0] m_wb_block,
    output logic        m_rd_valid,
    output logic        m_last
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int PW = $clog2(PIN_MAX + 1);
    localparam int BW = BLOCK_BITS;
    localparam logic [IW-1:0] TOP_RANK = IW'(NUM_SLOTS - 1);
    localparam logic [PW-1:0] PIN_TOP  = PW'(PIN_MAX);

    ctl_state_t state_reg, state_next;

    logic               valid_reg [NUM_SLOTS];
    logic               dirty_reg [NUM_SLOTS];
    logic [PW-1:0]      pins_reg  [NUM_SLOTS];
    logic [3:0]         dev_reg   [NUM_SLOTS];
    logic [IW-1:0]      rank_reg  [NUM_SLOTS];

    logic [2:0]         op_reg;
    logic [3:0]         dreq_reg;
    logic [BW-1:0]      breq_reg;
    logic [IW-1:0]      sreq_reg;
    logic               soor_reg, door_reg, rok_reg, wok_reg;

    logic [IW:0]        cnt_reg, cnt_next;
    logic               cen_reg, cen_next;
    logic [IW-1:0]      cidx_reg, cidx_next;
    logic               hit_reg, hit_next;
    logic [IW-1:0]      sel_reg, sel_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      vrank_reg, vrank_next;
    logic [BW-1:0]      vblk_reg, vblk_next;
    logic [NUM_SLOTS-1:0] mask_reg, mask_next, mask_init;
    logic [IW-1:0]      pick_reg, pick_next, low_idx;

    logic               m_valid_reg;
    logic [2:0]         m_status_reg;
    logic [IW-1:0]      m_slot_reg;
    logic               m_wbv_reg, m_rdv_reg, m_last_reg;
    logic [3:0]         m_wbdev_reg;
    logic [BW-1:0]      m_wbblk_reg;

    logic               emit, o_wbv, o_rdv, o_last;
    logic [2:0]         o_status;
    logic [IW-1:0]      o_slot;
    logic [3:0]         o_wbdev;
    logic [BW-1:0]      o_wbblk;

    logic               do_touch, pin_wr, val_wr, val_val, dty_wr, dty_val, dev_wr, ram_we;
    logic [IW-1:0]      touch_idx, pin_idx, val_idx, dty_idx, dev_idx, ram_wa, ram_ra;
    logic [PW-1:0]      pin_val;
    logic [3:0]         dev_val;
    logic [BW-1:0]      ram_wd, ram_q;

    logic [63:0]        blk_ext, slot_ext, oslot_ext, owb_ext;
    logic               out_free, accept;

    assign blk_ext   = 64'(s_block_num);
    assign slot_ext  = 64'(s_slot);
    assign oslot_ext = 64'(m_slot_reg);
    assign owb_ext   = 64'(m_wbblk_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            mask_init[i] = valid_reg[i] && dirty_reg[i]
                        && (s_opcode == OP_SYNC_ALL || dev_reg[i] == s_dev_id);
        end
        low_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                low_idx = IW'(i);
            end
        end
    end

    bcld_key_store #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (BW),
        .AW    (IW)
    ) u_keys (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_wa),
        .wdata (ram_wd),
        .raddr (ram_ra),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cen_next   = 1'b0;
        cidx_next  = cnt_reg[IW-1:0];
        hit_next   = hit_reg;
        sel_next   = sel_reg;
        found_next = found_reg;
        vrank_next = vrank_reg;
        vblk_next  = vblk_reg;
        mask_next  = mask_reg;
        pick_next  = pick_reg;
        ram_ra     = (state_reg == S_GET_SCAN) ? cnt_reg[IW-1:0] : pick_reg;

        emit = 1'b0; o_status = ST_OK; o_slot = '0; o_wbv = 1'b0; o_wbdev = '0;
        o_wbblk = '0; o_rdv = 1'b0; o_last = 1'b1;
        do_touch = 1'b0; touch_idx = '0;
        pin_wr = 1'b0; pin_idx = '0; pin_val = '0;
        val_wr = 1'b0; val_idx = '0; val_val = 1'b0;
        dty_wr = 1'b0; dty_idx = '0; dty_val = 1'b0;
        dev_wr = 1'b0; dev_idx = '0; dev_val = '0;
        ram_we = 1'b0; ram_wa = '0; ram_wd = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    found_next = 1'b0;
                    mask_next  = mask_init;
                    if (s_opcode == OP_GET && 32'(s_dev_id) < DEVICES) begin
                        state_next = S_GET_SCAN;
                    end else if (s_opcode == OP_SYNC_DEV || s_opcode == OP_SYNC_ALL) begin
                        state_next = S_SYNC_PICK;
                    end else begin
                        state_next = S_SINGLE;
                    end
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    o_status   = ST_IGNORED;
                    if (op_reg == OP_PUT && !soor_reg && pins_reg[sreq_reg] != '0) begin
                        o_status = ST_OK;
                        o_slot   = sreq_reg;
                        pin_wr   = 1'b1;
                        pin_idx  = sreq_reg;
                        pin_val  = pins_reg[sreq_reg] - 1'b1;
                    end else if (op_reg == OP_MARK && !soor_reg && valid_reg[sreq_reg]) begin
                        o_status = ST_OK;
                        o_slot   = sreq_reg;
                        dty_wr   = 1'b1;
                        dty_idx  = sreq_reg;
                        dty_val  = 1'b1;
                    end
                end
            end
            S_GET_SCAN: begin
                if (cnt_reg < (IW+1)'(NUM_SLOTS)) begin
                    cen_next = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (cen_reg) begin
                    if (pins_reg[cidx_reg] == '0
                            && (!found_reg || rank_reg[cidx_reg] < vrank_reg)) begin
                        found_next = 1'b1;
                        sel_next   = cidx_reg;
                        vrank_next = rank_reg[cidx_reg];
                        vblk_next  = ram_q;
                    end
                    if (valid_reg[cidx_reg] && dev_reg[cidx_reg] == dreq_reg
                            && ram_q == breq_reg) begin
                        hit_next   = 1'b1;
                        sel_next   = cidx_reg;
                        state_next = S_GET_RES;
                    end else if (cidx_reg == TOP_RANK) begin
                        state_next = S_GET_RES;
                    end
                end
            end
            S_GET_RES: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    o_slot     = sel_reg;
                    if (hit_reg) begin
                        o_status  = ST_OK;
                        do_touch  = 1'b1;
                        touch_idx = sel_reg;
                        pin_wr    = 1'b1;
                        pin_idx   = sel_reg;
                        pin_val   = (pins_reg[sel_reg] < PIN_TOP) ?
                                    pins_reg[sel_reg] + 1'b1 : pins_reg[sel_reg];
                    end else if (!found_reg) begin
                        o_status = ST_ALL_PIN;
                        o_slot   = '0;
                    end else begin
                        o_wbv   = valid_reg[sel_reg] && dirty_reg[sel_reg];
                        o_wbdev = o_wbv ? dev_reg[sel_reg] : '0;
                        o_wbblk = o_wbv ? vblk_reg : '0;
                        if (o_wbv && !wok_reg) begin
                            o_status = ST_WB_FAIL;
                        end else begin
                            o_rdv   = 1'b1;
                            dty_wr  = 1'b1;
                            dty_idx = sel_reg;
                            val_wr  = 1'b1;
                            val_idx = sel_reg;
                            dev_wr  = 1'b1;
                            dev_idx = sel_reg;
                            ram_we  = 1'b1;
                            ram_wa  = sel_reg;
                            if (!rok_reg) begin
                                o_status = ST_RD_FAIL;
                            end else begin
                                o_status  = ST_MISS;
                                val_val   = 1'b1;
                                dev_val   = dreq_reg;
                                ram_wd    = breq_reg;
                                pin_wr    = 1'b1;
                                pin_idx   = sel_reg;
                                pin_val   = PW'(1);
                                do_touch  = 1'b1;
                                touch_idx = sel_reg;
                            end
                        end
                    end
                end
            end
            S_SYNC_PICK: begin
                if (mask_reg == '0) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    pick_next           = low_idx;
                    mask_next[low_idx]  = 1'b0;
                    state_next          = S_SYNC_READ;
                end
            end
            S_SYNC_READ: begin
                state_next = S_SYNC_EMIT;
            end
            S_SYNC_EMIT: begin
                if (out_free) begin
                    emit     = 1'b1;
                    o_status = wok_reg ? ST_OK : ST_WB_FAIL;
                    o_slot   = pick_reg;
                    o_wbv    = 1'b1;
                    o_wbdev  = dev_reg[pick_reg];
                    o_wbblk  = ram_q;
                    o_last   = (mask_reg == '0);
                    dty_wr   = wok_reg;
                    dty_idx  = pick_reg;
                    state_next = (mask_reg == '0) ? S_IDLE : S_SYNC_PICK;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_opcode;
            dreq_reg <= s_dev_id;
            breq_reg <= blk_ext[BW-1:0];
            sreq_reg <= slot_ext[IW-1:0];
            soor_reg <= (32'(s_slot) >= NUM_SLOTS);
            door_reg <= (32'(s_dev_id) >= DEVICES);
            rok_reg  <= s_read_ok;
            wok_reg  <= s_write_ok;
        end
        cnt_reg   <= cnt_next;
        cidx_reg  <= cidx_next;
        sel_reg   <= sel_next;
        vrank_reg <= vrank_next;
        vblk_reg  <= vblk_next;
        pick_reg  <= pick_next;
        if (emit) begin
            m_status_reg <= door_reg && op_reg == OP_GET ? ST_IGNORED : o_status;
            m_slot_reg   <= o_slot;
            m_wbv_reg    <= o_wbv;
            m_wbdev_reg  <= o_wbdev;
            m_wbblk_reg  <= o_wbblk;
            m_rdv_reg    <= o_rdv;
            m_last_reg   <= o_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cen_reg     <= 1'b0;
            hit_reg     <= 1'b0;
            found_reg   <= 1'b0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                valid_reg[i] <= 1'b0;
                dirty_reg[i] <= 1'b0;
                pins_reg[i]  <= '0;
                dev_reg[i]   <= '0;
                rank_reg[i]  <= IW'(i);
            end
        end else begin
            cen_reg   <= cen_next;
            hit_reg   <= hit_next;
            found_reg <= found_next;
            mask_reg  <= mask_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (val_wr) begin
                valid_reg[val_idx] <= val_val;
            end
            if (dty_wr) begin
                dirty_reg[dty_idx] <= dty_val;
            end
            if (pin_wr) begin
                pins_reg[pin_idx] <= pin_val;
            end
            if (dev_wr) begin
                dev_reg[dev_idx] <= dev_val;
            end
            if (do_touch) begin
                for (int j = 0; j < NUM_SLOTS; j++) begin
                    if (IW'(j) == touch_idx) begin
                        rank_reg[j] <= TOP_RANK;
                    end else if (rank_reg[j] > rank_reg[touch_idx]) begin
                        rank_reg[j] <= rank_reg[j] - 1'b1;
                    end
                end
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_slot_out = oslot_ext[4:0];
    assign m_wb_valid = m_wbv_reg;
    assign m_wb_dev   = m_wbdev_reg;
    assign m_wb_block = owb_ext[31:0];
    assign m_rd_valid = m_rdv_reg;
    assign m_last     = m_last_reg;

endmodule

// ===== design/bcld_checker.sv =====
// ----------------------------------------------------------------------------
// Block cache LRU directory port checker
// Port-level checks on result encoding and request flow.
// ----------------------------------------------------------------------------
`include "block_cache_lru_directory_macros.svh"

module bcld_checker
    import bcld_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [2:0]  s_opcode,
    input logic [3:0]  s_dev_id,
    input logic [31:0] s_block_num,
    input logic [4:0]  s_slot,
    input logic        s_read_ok,
    input logic        s_write_ok,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [4:0]  m_slot_out,
    input logic        m_wb_valid,
    input logic [3:0]  m_wb_dev,
    input logic [31:0] m_wb_block,
    input logic        m_rd_valid,
    input logic        m_last
);

    `BCLD_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot_out) && $stable(m_wb_block) && $stable(m_last), "result changed while stalled")
    `BCLD_ASSERT(a_wb_zero, aclk, aresetn, m_valid && !m_wb_valid |-> m_wb_dev == 4'd0 && m_wb_block == 32'd0, "writeback key without writeback")
    `BCLD_ASSERT(a_rd_status, aclk, aresetn, m_valid && m_rd_valid |-> m_status == ST_MISS || m_status == ST_RD_FAIL, "read issued with wrong status")
    `BCLD_ASSERT(a_mid_sync, aclk, aresetn, m_valid && !m_last |-> m_wb_valid && !m_rd_valid, "non-final result is not a sync writeback")
    `BCLD_ASSERT(a_one_req, aclk, aresetn, s_valid && s_ready |=> !s_ready, "new request taken while busy")

endmodule

bind block_cache_lru_directory bcld_checker u_bcld_checker (.*);
